// File: hw/rtl/block_mark_bitmap_core_defines.svh
`ifndef BLOCK_MARK_BITMAP_CORE_DEFINES_SVH
`define BLOCK_MARK_BITMAP_CORE_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define BMB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap core check failed");

// Checks that a condition implies a consequence in the next cycle.
`define BMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap core check failed");

`endif

// File: hw/rtl/bmb_pkg.sv
`timescale 1ns / 1ps

package bmb_pkg;

   // Width of every bit index, limit and size field.
   localparam int FIELD_W = 17;

   // Width of the configuration data bus.
   localparam int CSR_DATA_W = 32;

   // Register index taken from the word address of the configuration port.
   localparam logic REG_MAP_BITS = 1'b0;

   // Map size after reset.
   localparam logic [FIELD_W-1:0] MAP_BITS_RESET = 17'd65536;

   // Operation codes.
   localparam logic [1:0] MODE_SET   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   // Status codes.
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef struct packed {
      logic [1:0]         mode;
      logic [FIELD_W-1:0] bit_offset;
      logic [FIELD_W-1:0] bit_limit;
   } req_type;

   typedef struct packed {
      logic               status;
      logic               all_set;
      logic [FIELD_W-1:0] run_end;
   } rsp_type;

endpackage

// File: hw/rtl/bmb_mem.sv
`timescale 1ns / 1ps

module bmb_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port: the word shows on rd_data in the cycle after rd_en.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bmb_engine.sv
`timescale 1ns / 1ps
`include "block_mark_bitmap_core_defines.svh"

module bmb_engine #(
   parameter int MAX_BITS  = 65536,
   parameter int WORD_BITS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  bmb_pkg::req_type                req,
   input  logic [bmb_pkg::FIELD_W-1:0]     map_size,
   output logic                            rsp_strobe,
   output bmb_pkg::rsp_type                rsp
);

   import bmb_pkg::*;

   localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BW         = $clog2(WORD_BITS);
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORD_COUNT - 1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [1:0]           mode_ff, mode_in;
   logic [FIELD_W-1:0]   off_ff, off_in;
   logic [FIELD_W-1:0]   hi_ff, hi_in;
   logic                 lim_hit_ff, lim_hit_in;
   logic [ADDR_W-1:0]    first_ff, first_in;
   logic [ADDR_W-1:0]    last_ff, last_in;
   logic [BW-1:0]        off_lo_ff, off_lo_in;
   logic [BW-1:0]        hi_lo_ff, hi_lo_in;
   logic [ADDR_W-1:0]    rd_addr_ff, rd_addr_in;
   logic                 more_ff, more_in;
   logic                 q_valid_ff, q_valid_in;
   logic [ADDR_W-1:0]    addr_q_ff, addr_q_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 rd_en;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] clear_bits;
   logic [BW-1:0]        lo_eff;
   logic [BW-1:0]        hi_eff;
   logic [BW-1:0]        clear_idx;
   logic                 at_last;
   logic                 done_now;

   logic                 walk;
   logic [FIELD_W-1:0]   lim_sz;
   logic [FIELD_W-1:0]   hi_new;
   logic [FIELD_W-1:0]   hi_m1;
   rsp_type              imm_rsp;

   // Lowest set bit of a word.
   function automatic logic [BW-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BW-1:0] idx;
      idx = '0;
      for (int p = WORD_BITS - 1; p >= 0; p--) begin
         if (v[p]) begin
            idx = BW'(p);
         end
      end
      return idx;
   endfunction

   bmb_mem #(
      .DEPTH  (WORD_COUNT),
      .ADDR_W (ADDR_W),
      .DATA_W (WORD_BITS)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Decode of a new command: the bit range to walk or an immediate answer.
   always_comb begin
      lim_sz  = (req.bit_limit < map_size) ? req.bit_limit : map_size;
      walk    = 1'b0;
      hi_new  = lim_sz;
      imm_rsp = '{status: STATUS_OK, all_set: 1'b0, run_end: req.bit_offset};
      unique case (req.mode)
         MODE_SET: begin
            if (req.bit_offset >= map_size) begin
               imm_rsp.status = STATUS_INVALID;
            end else begin
               walk   = 1'b1;
               hi_new = req.bit_offset + FIELD_W'(1);
            end
         end
         MODE_CLEAR: begin
            walk = (req.bit_offset < lim_sz);
         end
         MODE_QUERY: begin
            if (req.bit_offset >= map_size) begin
               imm_rsp.all_set = 1'b0;
            end else if (req.bit_offset >= req.bit_limit) begin
               imm_rsp.all_set = 1'b1;
            end else begin
               walk = 1'b1;
            end
         end
         default: begin
            walk = 1'b0;
         end
      endcase
      hi_m1 = hi_new - FIELD_W'(1);
   end

   // Bits of the returning word that fall inside the range.
   always_comb begin
      at_last = (addr_q_ff == last_ff);
      lo_eff  = (addr_q_ff == first_ff) ? off_lo_ff : '0;
      hi_eff  = at_last ? hi_lo_ff : '1;
      for (int p = 0; p < WORD_BITS; p++) begin
         mask[p] = (BW'(p) >= lo_eff) && (BW'(p) <= hi_eff);
      end
      clear_bits = ~rd_data & mask;
      clear_idx  = lowest_set(clear_bits);
   end

   // A walk ends on its last word, or early when a query finds a clear bit.
   assign done_now = (state_ff == ST_RUN) && q_valid_ff &&
                     (at_last || ((mode_ff == MODE_QUERY) && (clear_bits != '0)));

   assign rd_en = (state_ff == ST_RUN) && more_ff;

   // Write port: zeros during the clearing pass, else the modified word.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_q_ff;
      wr_data = rd_data & ~mask;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if ((state_ff == ST_RUN) && q_valid_ff && (mode_ff != MODE_QUERY)) begin
         wr_en   = 1'b1;
         wr_data = (mode_ff == MODE_SET) ? (rd_data | mask) : (rd_data & ~mask);
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      mode_in       = mode_ff;
      off_in        = off_ff;
      hi_in         = hi_ff;
      lim_hit_in    = lim_hit_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      off_lo_in     = off_lo_ff;
      hi_lo_in      = hi_lo_ff;
      rd_addr_in    = rd_addr_ff;
      more_in       = more_ff;
      q_valid_in    = rd_en && !done_now;
      addr_q_in     = rd_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               mode_in    = req.mode;
               off_in     = req.bit_offset;
               hi_in      = hi_new;
               lim_hit_in = (lim_sz == req.bit_limit);
               first_in   = ADDR_W'(req.bit_offset >> BW);
               last_in    = ADDR_W'(hi_m1 >> BW);
               off_lo_in  = req.bit_offset[BW-1:0];
               hi_lo_in   = hi_m1[BW-1:0];
               rd_addr_in = ADDR_W'(req.bit_offset >> BW);
               more_in    = 1'b1;
               if (walk) begin
                  state_in = ST_RUN;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = imm_rsp;
               end
            end
         end
         ST_RUN: begin
            if (rd_en) begin
               rd_addr_in = rd_addr_ff + ADDR_W'(1);
               more_in    = (rd_addr_ff != last_ff);
            end
            if (done_now) begin
               state_in       = ST_IDLE;
               more_in        = 1'b0;
               rsp_strobe_in  = 1'b1;
               rsp_in.status  = STATUS_OK;
               rsp_in.all_set = 1'b0;
               rsp_in.run_end = off_ff;
               if (mode_ff == MODE_QUERY) begin
                  if (clear_bits != '0) begin
                     rsp_in.run_end = FIELD_W'({addr_q_ff, clear_idx});
                  end else begin
                     rsp_in.run_end = hi_ff;
                     rsp_in.all_set = lim_hit_ff;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         more_ff       <= 1'b0;
         q_valid_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         more_ff       <= more_in;
         q_valid_ff    <= q_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Command and result registers.
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      off_ff     <= off_in;
      hi_ff      <= hi_in;
      lim_hit_ff <= lim_hit_in;
      first_ff   <= first_in;
      last_ff    <= last_in;
      off_lo_ff  <= off_lo_in;
      hi_lo_ff   <= hi_lo_in;
      rd_addr_ff <= rd_addr_in;
      addr_q_ff  <= addr_q_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   // An accepted command is either in progress or answered in the next cycle.
   `BMB_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe_ff)
   // No result is shown while the clearing pass runs.
   `BMB_ASSERT_SAME(a_no_rsp_in_clear, clock, reset, state_ff == ST_CLEAR, !rsp_strobe_ff)
   // A query never modifies the map.
   `BMB_ASSERT_SAME(a_query_no_write, clock, reset,
                    (state_ff == ST_RUN) && (mode_ff == MODE_QUERY), !wr_en)
   // Reads stay within the word range of the command.
   `BMB_ASSERT_SAME(a_read_in_range, clock, reset, rd_en,
                    (rd_addr_ff >= first_ff) && (rd_addr_ff <= last_ff))

endmodule

// File: hw/rtl/block_mark_bitmap_core.sv
`timescale 1ns / 1ps

// Bitmap of block marks, one bit per block, held in a word-wide memory.
// Commands: a word on req_data is taken at a clock edge where start is high
// and busy is low. Mode set marks one bit, mode clear clears a bit range,
// mode query reports the end of the run of set bits from the offset.
// Each command gives exactly one word on rsp_data, shown for one cycle with
// rsp_strobe high; the receiver cannot stall the block and must take it.
// A command that touches no word is answered in the cycle after it is taken.
// Otherwise it walks words first..last of its range through the memory's read
// port, one word per cycle, and is answered when the walk ends; a set touches
// one word. A query stops early at the word that holds its first clear bit.
// Busy is low again in the cycle that shows the result, so the next command
// may be taken there. Up to MAX_BITS / WORD_BITS words per command.
// Reset: map_bits returns to 65536 and a clearing pass over all MAX_BITS /
// WORD_BITS words (1024 by default) zeroes the memory, with busy high.
// The map_bits register sits on the APB port at byte address 0; the user must
// write it only while the block is idle, as the block does not enforce this.
module block_mark_bitmap_core #(
   parameter int MAX_BITS  = 65536,
   parameter int WORD_BITS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bmb_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output bmb_pkg::rsp_type                  rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [2:0]                        paddr,
   input  logic [bmb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bmb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   import bmb_pkg::*;

   localparam int SIZE_CAP = (MAX_BITS < 131071) ? MAX_BITS : 131071;
   localparam logic [FIELD_W-1:0] SIZE_CAP_F = FIELD_W'(SIZE_CAP);

   logic [FIELD_W-1:0] map_bits_ff, map_bits_in;
   logic [FIELD_W-1:0] map_size;
   logic               csr_write;

   // Configuration register.
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_MAP_BITS);

   always_comb begin
      map_bits_in = map_bits_ff;
      if (csr_write) begin
         map_bits_in = pwdata[FIELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_bits_ff <= MAP_BITS_RESET;
      end else begin
         map_bits_ff <= map_bits_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MAP_BITS) ? CSR_DATA_W'(map_bits_ff) : '0;

   // Size in use is the register capped to the memory.
   assign map_size = (map_bits_ff < SIZE_CAP_F) ? map_bits_ff : SIZE_CAP_F;

   bmb_engine #(
      .MAX_BITS  (MAX_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req_data),
      .map_size   (map_size),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bmb_pkg::*;

   // Mode code that the block leaves unused.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int unsigned MAP_LIMIT = 65536;
   localparam int unsigned MARK_W = 64;
   localparam int unsigned MARK_DEPTH = MAP_LIMIT / MARK_W;

   // Tracks the bitmap and the answers that are still due from the block.
   class bitmap_scoreboard;
      bit [MARK_W-1:0] marks [MARK_DEPTH];
      logic [FIELD_W-1:0] size_reg;
      rsp_type answers_due [$];
      int unsigned failures;

      function new();
         foreach (marks[i]) marks[i] = '0;
         size_reg = MAP_BITS_RESET;
         failures = 0;
      endfunction

      function int unsigned span();
         return (size_reg > MAP_LIMIT) ? MAP_LIMIT : int'(size_reg);
      endfunction

      // Bit 0 of a word is its most significant bit.
      function bit mark_at(int unsigned b);
         return marks[b / MARK_W][MARK_W - 1 - (b % MARK_W)];
      endfunction

      function void put_mark(int unsigned b, bit v);
         marks[b / MARK_W][MARK_W - 1 - (b % MARK_W)] = v;
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10) $display("mismatch: %s", what);
      endfunction

      // Applies one accepted command word and queues the answer it must produce.
      function void take_command(req_type cmd);
         rsp_type ans;
         int unsigned off, lim, eff, hi, b;
         off = cmd.bit_offset;
         lim = cmd.bit_limit;
         eff = span();
         ans.status = STATUS_OK;
         ans.all_set = 1'b0;
         ans.run_end = cmd.bit_offset;
         case (cmd.mode)
            MODE_SET: begin
               if (off >= eff) ans.status = STATUS_INVALID;
               else put_mark(off, 1'b1);
            end
            MODE_CLEAR: begin
               hi = (lim < eff) ? lim : eff;
               for (b = off; b < hi; b++) put_mark(b, 1'b0);
            end
            MODE_QUERY: begin
               if (off >= eff) begin
                  ans.all_set = 1'b0;
               end else if (off >= lim) begin
                  ans.all_set = 1'b1;
               end else begin
                  b = off;
                  while (b < lim && b < eff && mark_at(b)) b++;
                  ans.run_end = FIELD_W'(b);
                  ans.all_set = (b == lim);
               end
            end
            default: ;
         endcase
         answers_due.push_back(ans);
      endfunction

      // Compares one answer word with the oldest one still due.
      function void match_answer(rsp_type got);
         rsp_type want;
         if (answers_due.size() == 0) begin
            flag($sformatf("answer with none due: status %0d all_set %0d run_end %0d",
                           got.status, got.all_set, got.run_end));
            return;
         end
         want = answers_due.pop_front();
         if (got.status !== want.status || got.all_set !== want.all_set ||
             got.run_end !== want.run_end)
            flag($sformatf("expected status %0d all_set %0d run_end %0d, got %0d %0d %0d",
                           want.status, want.all_set, want.run_end,
                           got.status, got.all_set, got.run_end));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   bitmap_scoreboard book;
   int unsigned idle_pct;
   int unsigned issued;

   block_mark_bitmap_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #50_000_000;
      $display("block_mark_bitmap_core verification failed");
      $finish;
   end

   // Every answer word is taken at the edge that ends its strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) book.match_answer(rsp_data);
   end

   function automatic req_type make_cmd(logic [1:0] mode, int unsigned off, int unsigned lim);
      req_type c;
      c.mode = mode;
      c.bit_offset = FIELD_W'(off);
      c.bit_limit = FIELD_W'(lim);
      return c;
   endfunction

   // Offers one command word, with an optional gap first; start stays high afterwards.
   task automatic send_cmd(input req_type cmd);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (busy);
      book.take_command(cmd);
      issued++;
   endtask

   // Writes map_bits once the block is idle and reads it back.
   task automatic csr_update(input logic [FIELD_W-1:0] value);
      logic [CSR_DATA_W-1:0] seen;
      start <= 1'b0;
      while (book.answers_due.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (3) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {REG_MAP_BITS, 2'b00};
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      book.size_reg = value;
      // Select stays high so the read-back setup follows at once.
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      seen = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (seen !== CSR_DATA_W'(value))
         book.flag($sformatf("map_bits read back: expected %0d, got %0d", value, seen));
   endtask

   // Fills a run of bits, then queries and nicks it.
   task automatic fill_run();
      int unsigned base, len, cut;
      base = $urandom_range(0, book.span() - 1);
      len = $urandom_range(1, 70);
      for (int unsigned i = 0; i < len; i++)
         send_cmd(make_cmd(MODE_SET, base + i, $urandom));
      send_cmd(make_cmd(MODE_QUERY, base + $urandom_range(0, len - 1),
                        base + $urandom_range(0, len + 40)));
      cut = base + $urandom_range(0, len);
      send_cmd(make_cmd(MODE_CLEAR, cut, cut + $urandom_range(0, 16)));
      send_cmd(make_cmd(MODE_QUERY, base, base + len + $urandom_range(0, 2)));
   endtask

   // Random traffic: mostly filled runs, else single commands near the map or noise.
   task automatic run_random(input int unsigned count);
      int unsigned goal, pick, off, lim, back;
      req_type cmd;
      goal = issued + count;
      while (issued < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            fill_run();
         end else if (pick < 90) begin
            off = $urandom_range(0, book.span() + 4);
            if ($urandom_range(0, 3) == 0) begin
               back = $urandom_range(0, 8);
               lim = (off >= back) ? off - back : 0;
            end else begin
               lim = off + $urandom_range(0, 256);
            end
            send_cmd(make_cmd(2'($urandom_range(0, 2)), off, lim));
         end else begin
            cmd.mode = 2'($urandom);
            cmd.bit_offset = FIELD_W'($urandom);
            cmd.bit_limit = FIELD_W'($urandom);
            send_cmd(cmd);
         end
      end
   endtask

   initial begin
      int unsigned n;
      book = new();
      idle_pct = 0;
      issued = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // Let the clearing pass begin before anything waits on busy.
      repeat (2) @(posedge clock);

      // Directed: field extremes, every mode and the corner cases, at full size.
      send_cmd(make_cmd(MODE_SET, 0, 0));
      send_cmd(make_cmd(MODE_SET, 1, 0));
      send_cmd(make_cmd(MODE_SET, 2, 0));
      send_cmd(make_cmd(MODE_SET, 63, 0));
      send_cmd(make_cmd(MODE_SET, 64, 0));
      send_cmd(make_cmd(MODE_SET, 65535, 0));
      send_cmd(make_cmd(MODE_SET, 65536, 0));
      send_cmd(make_cmd(MODE_SET, 131071, 131071));
      send_cmd(make_cmd(MODE_QUERY, 0, 3));
      send_cmd(make_cmd(MODE_QUERY, 0, 10));
      send_cmd(make_cmd(MODE_QUERY, 5, 5));
      send_cmd(make_cmd(MODE_QUERY, 10, 4));
      send_cmd(make_cmd(MODE_QUERY, 65535, 65536));
      send_cmd(make_cmd(MODE_QUERY, 65535, 131071));
      send_cmd(make_cmd(MODE_QUERY, 65536, 65537));
      send_cmd(make_cmd(MODE_CLEAR, 1, 3));
      send_cmd(make_cmd(MODE_QUERY, 0, 65));
      send_cmd(make_cmd(MODE_CLEAR, 65535, 131071));
      send_cmd(make_cmd(MODE_CLEAR, 5, 2));
      send_cmd(make_cmd(MODE_UNUSED, 7, 9));
      send_cmd(make_cmd(MODE_QUERY, 0, 65536));
      send_cmd(make_cmd(MODE_CLEAR, 0, 65536));

      // Zero size puts every bit out of range.
      csr_update(FIELD_W'(0));
      send_cmd(make_cmd(MODE_SET, 0, 0));
      send_cmd(make_cmd(MODE_QUERY, 0, 1));
      send_cmd(make_cmd(MODE_CLEAR, 0, 10));

      // Bits past a small map count as clear.
      csr_update(FIELD_W'(100));
      send_cmd(make_cmd(MODE_SET, 99, 0));
      send_cmd(make_cmd(MODE_SET, 100, 0));
      send_cmd(make_cmd(MODE_QUERY, 99, 200));

      // Sender idles rarely.
      idle_pct = 8;
      csr_update(MAP_BITS_RESET);
      run_random(70);
      csr_update(FIELD_W'($urandom_range(2, 65535)));
      run_random(70);

      // Sender idles often, small maps.
      idle_pct = 55;
      csr_update(FIELD_W'(1));
      run_random(40);
      csr_update(FIELD_W'($urandom_range(64, 400)));
      run_random(90);

      // No idling; an oversized register value clamps to the full map.
      idle_pct = 0;
      csr_update(FIELD_W'(131071));
      run_random(70);
      csr_update(FIELD_W'($urandom_range(500, 3000)));
      run_random(70);

      // Drain the answers still due, then let the block settle.
      start <= 1'b0;
      for (n = 0; n < 3000 && book.answers_due.size() != 0; n++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (book.answers_due.size() != 0)
         book.flag($sformatf("%0d answers never arrived", book.answers_due.size()));

      if (book.failures == 0) begin
         $display("block_mark_bitmap_core verification clean");
      end else begin
         $display("block_mark_bitmap_core verification failed");
      end
      $finish;
   end

endmodule
